// ===== hdl/wmc_pkg.sv =====
package wmc_pkg;

    localparam int WINDOW_LEN  = 40;
    localparam int PIXEL_W     = 8;
    localparam int TOTAL_W     = 14;
    localparam int MEAN_W      = 8;
    localparam int LEVEL_W     = 8;
    localparam int LEVEL_MAX   = 199;
    localparam int CURVE_SCALE = 200;
    localparam int CURVE_KNEE  = 125;
    localparam int TABLE_DEPTH = 1 << MEAN_W;

    // floor(x / WINDOW_LEN) ~= (x * RECIP) >> RECIP_SHIFT, low by at most one
    localparam int RECIP_SHIFT = TOTAL_W;
    localparam int RECIP       = (1 << RECIP_SHIFT) / WINDOW_LEN;
    localparam int RECIP_W     = $clog2(RECIP + 1);
    localparam int PROD_W      = TOTAL_W + RECIP_W;

    localparam int QUEUE_DEPTH = 8;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

    typedef logic [TABLE_DEPTH-1:0][LEVEL_W-1:0] level_table_t;

    typedef struct packed {
        logic              valid;
        logic [MEAN_W-1:0] diff;
    } diff_push_t;

    typedef struct packed {
        logic not_empty;
        logic full;
    } queue_stat_t;

    // level = floor(SCALE*d*d / (KNEE + d*d)); shift-subtract, quotient fits LEVEL_W bits
    function automatic level_table_t build_level_table();
        level_table_t tbl;
        int sq;
        int rem;
        int den;
        int q;
        for (int d = 0; d < TABLE_DEPTH; d++)
        begin
            sq  = d * d;
            rem = CURVE_SCALE * sq;
            den = CURVE_KNEE + sq;
            q   = 0;
            for (int b = LEVEL_W - 1; b >= 0; b--)
            begin
                if (rem >= (den << b))
                begin
                    rem = rem - (den << b);
                    q   = q | (1 << b);
                end
            end
            tbl[d] = LEVEL_W'(q);
        end
        return tbl;
    endfunction

    localparam level_table_t LEVEL_TABLE = build_level_table();

endpackage

// ===== hdl/wmc_front.sv =====
module wmc_front
    import wmc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               row_start,
    input  logic [PIXEL_W-1:0] left_pixel,
    input  logic [PIXEL_W-1:0] right_pixel,
    input  logic               pop,
    output diff_push_t         push
);

    logic [PIXEL_W-1:0] left_tap_reg  [WINDOW_LEN];
    logic [PIXEL_W-1:0] right_tap_reg [WINDOW_LEN];
    logic [WINDOW_LEN-1:0] tap_valid_reg, tap_valid_next;

    logic [TOTAL_W-1:0] left_total_reg, left_total_next;
    logic [TOTAL_W-1:0] right_total_reg, right_total_next;

    logic [COUNT_W-1:0] pending_reg, pending_next;

    logic accept;
    logic [PIXEL_W-1:0] left_out, right_out;

    // stage A: updated totals
    logic               a_valid_reg;

    // stage B: reciprocal products
    logic               b_valid_reg;
    logic [MEAN_W-1:0]  b_left_q_reg, b_right_q_reg;
    logic [TOTAL_W-1:0] b_left_total_reg, b_right_total_reg;
    logic [PROD_W-1:0]  left_prod, right_prod;

    // stage C: corrected means
    logic               c_valid_reg;
    logic [MEAN_W-1:0]  c_left_mean_reg, c_right_mean_reg;
    logic [TOTAL_W-1:0] left_rem, right_rem;
    logic [MEAN_W-1:0]  left_mean, right_mean;

    assign accept   = in_valid && in_ready;
    assign in_ready = (pending_reg < COUNT_W'(QUEUE_DEPTH));

    always_comb
    begin
        pending_next = pending_reg;
        if (accept && !pop)
            pending_next = pending_reg + COUNT_W'(1);
        else if (!accept && pop)
            pending_next = pending_reg - COUNT_W'(1);
    end

    // sample leaving the window; cleared taps count as zero
    assign left_out  = (tap_valid_reg[WINDOW_LEN-1] && !row_start)
                       ? left_tap_reg[WINDOW_LEN-1]  : '0;
    assign right_out = (tap_valid_reg[WINDOW_LEN-1] && !row_start)
                       ? right_tap_reg[WINDOW_LEN-1] : '0;

    always_comb
    begin
        left_total_next  = left_total_reg;
        right_total_next = right_total_reg;
        tap_valid_next   = tap_valid_reg;
        if (accept)
        begin
            left_total_next  = (row_start ? '0 : left_total_reg)
                               - TOTAL_W'(left_out) + TOTAL_W'(left_pixel);
            right_total_next = (row_start ? '0 : right_total_reg)
                               - TOTAL_W'(right_out) + TOTAL_W'(right_pixel);
            tap_valid_next   = row_start ? WINDOW_LEN'(1)
                                         : {tap_valid_reg[WINDOW_LEN-2:0], 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_valid_reg   <= '0;
            left_total_reg  <= '0;
            right_total_reg <= '0;
            pending_reg     <= '0;
            a_valid_reg     <= 1'b0;
            b_valid_reg     <= 1'b0;
            c_valid_reg     <= 1'b0;
        end
        else
        begin
            tap_valid_reg   <= tap_valid_next;
            left_total_reg  <= left_total_next;
            right_total_reg <= right_total_next;
            pending_reg     <= pending_next;
            a_valid_reg     <= accept;
            b_valid_reg     <= a_valid_reg;
            c_valid_reg     <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            left_tap_reg[0]  <= left_pixel;
            right_tap_reg[0] <= right_pixel;
            for (int i = 1; i < WINDOW_LEN; i++)
            begin
                left_tap_reg[i]  <= left_tap_reg[i-1];
                right_tap_reg[i] <= right_tap_reg[i-1];
            end
        end
    end

    // totals registers hold the item from the previous transfer here
    assign left_prod  = PROD_W'(left_total_reg)  * PROD_W'(RECIP);
    assign right_prod = PROD_W'(right_total_reg) * PROD_W'(RECIP);

    always_ff @(posedge clk)
    begin
        b_left_q_reg      <= left_prod[RECIP_SHIFT +: MEAN_W];
        b_right_q_reg     <= right_prod[RECIP_SHIFT +: MEAN_W];
        b_left_total_reg  <= left_total_reg;
        b_right_total_reg <= right_total_reg;
    end

    assign left_rem   = b_left_total_reg  - TOTAL_W'(b_left_q_reg  * WINDOW_LEN);
    assign right_rem  = b_right_total_reg - TOTAL_W'(b_right_q_reg * WINDOW_LEN);
    assign left_mean  = b_left_q_reg
                        + MEAN_W'(left_rem  >= TOTAL_W'(WINDOW_LEN));
    assign right_mean = b_right_q_reg
                        + MEAN_W'(right_rem >= TOTAL_W'(WINDOW_LEN));

    always_ff @(posedge clk)
    begin
        c_left_mean_reg  <= left_mean;
        c_right_mean_reg <= right_mean;
    end

    assign push.valid = c_valid_reg;
    assign push.diff  = (c_left_mean_reg > c_right_mean_reg)
                        ? c_left_mean_reg - c_right_mean_reg
                        : c_right_mean_reg - c_left_mean_reg;

endmodule

// ===== hdl/wmc_queue.sv =====
module wmc_queue
    import wmc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  diff_push_t        push,
    input  logic              pop,
    output logic [MEAN_W-1:0] head,
    output queue_stat_t       stat
);

    logic [MEAN_W-1:0]   entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [COUNT_W-1:0]  count_reg, count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push.valid && !pop)
            count_next = count_reg + COUNT_W'(1);
        else if (!push.valid && pop)
            count_next = count_reg - COUNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push.valid)
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + QUEUE_AW'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + QUEUE_AW'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
            entry_reg[wr_ptr_reg] <= push.diff;
    end

    assign head           = entry_reg[rd_ptr_reg];
    assign stat.not_empty = (count_reg != '0);
    assign stat.full      = (count_reg == COUNT_W'(QUEUE_DEPTH));

endmodule

// ===== hdl/wmc_back.sv =====
module wmc_back
    import wmc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [MEAN_W-1:0]  head,
    input  queue_stat_t        stat,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [LEVEL_W-1:0] level
);

    logic               out_valid_reg;
    logic [LEVEL_W-1:0] level_reg;

    assign pop = stat.not_empty && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pop)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            level_reg <= LEVEL_TABLE[head];
    end

    assign out_valid = out_valid_reg;
    assign level     = level_reg;

endmodule

// ===== hdl/window_mean_contrast_map_core.sv =====
// An input transfer passes the totals, product and mean registers, the queue and the level register.
// Throughput: one item per cycle while s_axis_tready is high, set by window shift and total update.
// An 8-entry queue sits between the mean pipeline and the table/output register;
// s_axis_tready drops once 8 items are in flight and not yet taken by the back end.
// Reset (rst_n low, async): windows and totals read as zero, pipeline and queue empty.
module window_mean_contrast_map_core
    import wmc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [2*PIXEL_W-1:0] s_axis_tdata,  // right_pixel in the high byte, left_pixel in the low byte
    input  logic                 s_axis_tuser,  // row_start
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [LEVEL_W-1:0]   m_axis_tdata   // level
);

    diff_push_t        push;
    queue_stat_t       stat;
    logic              pop;
    logic [MEAN_W-1:0] head;

    wmc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .row_start   (s_axis_tuser),
        .left_pixel  (s_axis_tdata[PIXEL_W-1:0]),
        .right_pixel (s_axis_tdata[2*PIXEL_W-1:PIXEL_W]),
        .pop         (pop),
        .push        (push)
    );

    wmc_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .stat  (stat)
    );

    wmc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .stat      (stat),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .level     (m_axis_tdata)
    );

    // credit count must keep the queue from overrunning
    assert property (@(posedge clk) disable iff (!rst_n)
        !(push.valid && stat.full && !pop))
    else $error("diff queue overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> stat.not_empty)
    else $error("pop from empty diff queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata <= LEVEL_W'(LEVEL_MAX)))
    else $error("level out of range");

endmodule

// ===== tb/sv/window_mean_contrast_map_core_test.sv =====
module window_mean_contrast_map_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import wmc_pkg::*;

    localparam int RANDOM_ITEMS   = 2000;
    localparam int HOLD_CYCLES    = 120;
    localparam int DRAIN_CYCLES   = 24;
    localparam int DIRECTED_COUNT = 20;

    typedef struct packed {
        logic               row_start;
        logic [PIXEL_W-1:0] left_px;
        logic [PIXEL_W-1:0] right_px;
        logic               has_level;
        logic [LEVEL_W-1:0] level;
    } stim_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [2*PIXEL_W-1:0] s_axis_tdata = '0;    // right_pixel in the high byte, left_pixel in the low byte
    logic                 s_axis_tuser = 1'b0;  // row_start
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [LEVEL_W-1:0]   m_axis_tdata;         // level

    // predictor state
    logic [PIXEL_W-1:0] left_hist  [WINDOW_LEN];
    logic [PIXEL_W-1:0] right_hist [WINDOW_LEN];
    int unsigned        hist_slot;
    logic [TOTAL_W-1:0] left_acc;
    logic [TOTAL_W-1:0] right_acc;

    logic [LEVEL_W-1:0] expected_levels [$];

    int errors = 0;
    int items_sent = 0;
    int levels_seen = 0;
    int rows_started = 0;
    int phase = 0;
    int send_idle_pct = 24;
    int recv_idle_pct = 74;
    int hold_req = 0;
    int hold_taken = 0;
    int hold_left = 0;
    int stalled_cycles = 0;

    // fixed levels: equal means give 0, one item of 255 against 0 gives d=6 -> 44
    stim_row_t directed_rows [DIRECTED_COUNT] = '{
        '{1'b1, 8'h00, 8'h00, 1'b1, 8'd0},
        '{1'b0, 8'hFF, 8'hFF, 1'b1, 8'd0},
        '{1'b1, 8'hFF, 8'h00, 1'b1, 8'd44},
        '{1'b0, 8'hFF, 8'h00, 1'b0, 8'd0},
        '{1'b0, 8'hFF, 8'h00, 1'b0, 8'd0},
        '{1'b0, 8'hFF, 8'h00, 1'b0, 8'd0},
        '{1'b1, 8'h00, 8'hFF, 1'b1, 8'd44},
        '{1'b0, 8'h00, 8'hFF, 1'b0, 8'd0},
        '{1'b0, 8'h00, 8'hFF, 1'b0, 8'd0},
        '{1'b0, 8'h80, 8'h7F, 1'b0, 8'd0},
        '{1'b1, 8'h80, 8'h7F, 1'b1, 8'd0},
        '{1'b0, 8'h01, 8'hFE, 1'b0, 8'd0},
        '{1'b0, 8'hFE, 8'h01, 1'b0, 8'd0},
        '{1'b0, 8'hAA, 8'h55, 1'b0, 8'd0},
        '{1'b0, 8'h55, 8'hAA, 1'b0, 8'd0},
        '{1'b1, 8'h7F, 8'h80, 1'b1, 8'd0},
        '{1'b0, 8'hFF, 8'hFF, 1'b0, 8'd0},
        '{1'b0, 8'h00, 8'h00, 1'b0, 8'd0},
        '{1'b1, 8'h00, 8'h00, 1'b1, 8'd0},
        '{1'b0, 8'hFF, 8'h00, 1'b0, 8'd0}
    };

    window_mean_contrast_map_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #2000000;
        $display("Timeout at %0t with %0d levels outstanding", $time, expected_levels.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic clear_windows();
        int i;
        for (i = 0; i < WINDOW_LEN; i++)
        begin
            left_hist[i]  = '0;
            right_hist[i] = '0;
        end
        left_acc  = '0;
        right_acc = '0;
    endtask

    // slide both windows by one pair and map the mean difference to a gray level
    task automatic predict_level(input logic rs, input logic [PIXEL_W-1:0] lp,
                                 input logic [PIXEL_W-1:0] rp,
                                 output logic [LEVEL_W-1:0] lvl);
        int unsigned lmean;
        int unsigned rmean;
        int unsigned d;
        int unsigned sq;
        if (rs)
            clear_windows();
        if (hist_slot >= WINDOW_LEN)
            hist_slot = 0;
        left_acc  = left_acc - left_hist[hist_slot] + lp;
        right_acc = right_acc - right_hist[hist_slot] + rp;
        left_hist[hist_slot]  = lp;
        right_hist[hist_slot] = rp;
        hist_slot = hist_slot + 1;
        if (hist_slot >= WINDOW_LEN)
            hist_slot = 0;
        lmean = left_acc / WINDOW_LEN;
        rmean = right_acc / WINDOW_LEN;
        d  = ((lmean > rmean) ? (lmean - rmean) : (rmean - lmean)) & 8'hFF;
        sq = d * d;
        lvl = LEVEL_W'((CURVE_SCALE * sq) / (CURVE_KNEE + sq));
    endtask

    task automatic send_pair(input logic rs, input logic [PIXEL_W-1:0] lp,
                             input logic [PIXEL_W-1:0] rp, input logic has_level,
                             input logic [LEVEL_W-1:0] fixed_level);
        logic [LEVEL_W-1:0] lvl;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {rp, lp};
        s_axis_tuser  <= rs;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_level(rs, lp, rp, lvl);
        expected_levels.push_back(has_level ? fixed_level : lvl);
        items_sent++;
        if (rs)
            rows_started++;
    endtask

    task automatic set_phase(input int p);
        phase = p;
        case (p)
            0:
            begin
                send_idle_pct = 24;
                recv_idle_pct = 74;
                hold_req++;
            end
            1:
            begin
                send_idle_pct = 74;
                recv_idle_pct = 24;
            end
            default:
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_req++;
            end
        endcase
    endtask

    function automatic logic [PIXEL_W-1:0] pick_base();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return PIXEL_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [PIXEL_W-1:0] jitter(input logic [PIXEL_W-1:0] base);
        int v;
        v = int'(base) + int'($urandom_range(0, 8)) - 4;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return PIXEL_W'(v);
    endfunction

    // one row of flat or noisy regions; longer rows fill the windows and let the means drift apart
    task automatic send_row();
        int len;
        int seg;
        int k;
        logic first;
        logic noisy;
        logic [PIXEL_W-1:0] lbase;
        logic [PIXEL_W-1:0] rbase;
        len   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 39) : $urandom_range(40, 160);
        first = 1'b1;
        while (len > 0)
        begin
            seg   = $urandom_range(1, 60);
            lbase = pick_base();
            rbase = pick_base();
            noisy = ($urandom_range(0, 4) == 0);
            for (k = 0; k < seg && len > 0; k++)
            begin
                if (noisy)
                    send_pair(first, PIXEL_W'($urandom), PIXEL_W'($urandom), 1'b0, '0);
                else
                    send_pair(first, jitter(lbase), jitter(rbase), 1'b0, '0);
                first = 1'b0;
                len--;
            end
        end
    endtask

    // receiver: random idling, plus a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_left != 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req != hold_taken)
        begin
            m_axis_tready <= 1'b0;
            hold_taken <= hold_taken + 1;
            hold_left <= HOLD_CYCLES;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && !s_axis_tready)
            stalled_cycles++;
    end

    always @(posedge clk)
    begin : check_level
        logic [LEVEL_W-1:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            levels_seen++;
            if (expected_levels.size() == 0)
            begin
                errors++;
                $display("%0t: level transfer with nothing expected: expected none, actual %0d",
                         $time, m_axis_tdata);
            end
            else
            begin
                want = expected_levels.pop_front();
                if (m_axis_tdata !== want)
                begin
                    errors++;
                    $display("%0t: level mismatch: expected %0d, actual %0d",
                             $time, want, m_axis_tdata);
                end
            end
        end
    end

    initial
    begin
        int i;
        clear_windows();
        hist_slot = 0;
        set_phase(0);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIRECTED_COUNT; i++)
            send_pair(directed_rows[i].row_start, directed_rows[i].left_px,
                      directed_rows[i].right_px, directed_rows[i].has_level,
                      directed_rows[i].level);

        while (items_sent < DIRECTED_COUNT + RANDOM_ITEMS)
        begin
            if (phase == 0 && items_sent >= DIRECTED_COUNT + RANDOM_ITEMS / 3)
                set_phase(1);
            else if (phase == 1 && items_sent >= DIRECTED_COUNT + 2 * RANDOM_ITEMS / 3)
                set_phase(2);
            if ($urandom_range(0, 99) < 80)
                send_row();
            else
                repeat ($urandom_range(1, 8))
                    send_pair(($urandom_range(0, 7) == 0), PIXEL_W'($urandom),
                              PIXEL_W'($urandom), 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;

        while (expected_levels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d pixel pairs in %0d rows, checked %0d levels", items_sent,
                 rows_started, levels_seen);
        $display("Input stalled by the block for %0d cycles across three idling mixes",
                 stalled_cycles);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== window_mean_contrast_map_core.f =====
hdl/wmc_pkg.sv
hdl/wmc_front.sv
hdl/wmc_queue.sv
hdl/wmc_back.sv
hdl/window_mean_contrast_map_core.sv
tb/sv/window_mean_contrast_map_core_test.sv
